@@ design/segint_pkg.sv @@
`default_nettype none

package segint_pkg;

   // width of every coordinate port
   localparam int FIELD_BITS = 16;

   // default coordinate width taken from each port
   localparam int COORD_BITS_DEFAULT = 16;

   // outcome codes
   typedef enum logic [1:0] {
      OUT_CROSS    = 2'd0,
      OUT_MISS     = 2'd1,
      OUT_POINT    = 2'd2,
      OUT_PARALLEL = 2'd3
   } outcome_type;

   // control that travels with each word down the pipeline
   typedef struct packed {
      logic valid;
      logic point;
   } stage_ctl_type;

endpackage

`default_nettype wire

@@ design/segint_diff.sv @@
`default_nettype none

module segint_diff
   import segint_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic signed [FIELD_BITS-1:0] seg1_start_x,
   input  wire logic signed [FIELD_BITS-1:0] seg1_start_y,
   input  wire logic signed [FIELD_BITS-1:0] seg1_end_x,
   input  wire logic signed [FIELD_BITS-1:0] seg1_end_y,
   input  wire logic signed [FIELD_BITS-1:0] seg2_start_x,
   input  wire logic signed [FIELD_BITS-1:0] seg2_start_y,
   input  wire logic signed [FIELD_BITS-1:0] seg2_end_x,
   input  wire logic signed [FIELD_BITS-1:0] seg2_end_y,
   output logic                              out_valid,
   output logic signed [COORD_BITS:0]        rx,
   output logic signed [COORD_BITS:0]        ry,
   output logic signed [COORD_BITS:0]        sx,
   output logic signed [COORD_BITS:0]        sy,
   output logic signed [COORD_BITS:0]        wx,
   output logic signed [COORD_BITS:0]        wy
);

   localparam int TAKE = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;

   logic                     valid_ff;
   logic signed [COORD_BITS:0] rx_ff, ry_ff, sx_ff, sy_ff, wx_ff, wy_ff;
   logic signed [COORD_BITS:0] rx_in, ry_in, sx_in, sy_in, wx_in, wy_in;
   logic signed [COORD_BITS:0] px, py, ex, ey, qx, qy, fx, fy;

   // low coordinate bits as two's complement, one guard bit for the difference
   function automatic logic signed [COORD_BITS:0] widen(input logic [FIELD_BITS-1:0] raw);
      logic [COORD_BITS-1:0] v;
      v = COORD_BITS'(raw[TAKE-1:0]);
      return {v[COORD_BITS-1], v};
   endfunction

   assign px = widen(seg1_start_x);
   assign py = widen(seg1_start_y);
   assign ex = widen(seg1_end_x);
   assign ey = widen(seg1_end_y);
   assign qx = widen(seg2_start_x);
   assign qy = widen(seg2_start_y);
   assign fx = widen(seg2_end_x);
   assign fy = widen(seg2_end_y);

   // direction vectors and start offset
   always_comb begin
      rx_in = ex - px;
      ry_in = ey - py;
      sx_in = fx - qx;
      sy_in = fy - qy;
      wx_in = qx - px;
      wy_in = qy - py;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      wx_ff <= wx_in;
      wy_ff <= wy_in;
   end

   assign out_valid = valid_ff;
   assign rx        = rx_ff;
   assign ry        = ry_ff;
   assign sx        = sx_ff;
   assign sy        = sy_ff;
   assign wx        = wx_ff;
   assign wy        = wy_ff;

endmodule

`default_nettype wire

@@ design/segint_mult.sv @@
`default_nettype none

module segint_mult
   import segint_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic signed [COORD_BITS:0]        rx,
   input  wire logic signed [COORD_BITS:0]        ry,
   input  wire logic signed [COORD_BITS:0]        sx,
   input  wire logic signed [COORD_BITS:0]        sy,
   input  wire logic signed [COORD_BITS:0]        wx,
   input  wire logic signed [COORD_BITS:0]        wy,
   output stage_ctl_type                          ctl_out,
   output logic signed [2*COORD_BITS+1:0]         rx_sy,
   output logic signed [2*COORD_BITS+1:0]         ry_sx,
   output logic signed [2*COORD_BITS+1:0]         wx_sy,
   output logic signed [2*COORD_BITS+1:0]         wy_sx,
   output logic signed [2*COORD_BITS+1:0]         wx_ry,
   output logic signed [2*COORD_BITS+1:0]         wy_rx
);

   localparam int PW = 2*COORD_BITS + 2;

   stage_ctl_type        ctl_ff, ctl_in;
   logic signed [PW-1:0] rx_sy_ff, ry_sx_ff, wx_sy_ff, wy_sx_ff, wx_ry_ff, wy_rx_ff;

   // either segment degenerate to a point
   always_comb begin
      ctl_in.valid = in_valid;
      ctl_in.point = ((rx == '0) && (ry == '0)) || ((sx == '0) && (sy == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // six cross-product terms, one multiplier each
   always_ff @(posedge clock) begin
      rx_sy_ff <= PW'(rx) * PW'(sy);
      ry_sx_ff <= PW'(ry) * PW'(sx);
      wx_sy_ff <= PW'(wx) * PW'(sy);
      wy_sx_ff <= PW'(wy) * PW'(sx);
      wx_ry_ff <= PW'(wx) * PW'(ry);
      wy_rx_ff <= PW'(wy) * PW'(rx);
   end

   assign ctl_out = ctl_ff;
   assign rx_sy   = rx_sy_ff;
   assign ry_sx   = ry_sx_ff;
   assign wx_sy   = wx_sy_ff;
   assign wy_sx   = wy_sx_ff;
   assign wx_ry   = wx_ry_ff;
   assign wy_rx   = wy_rx_ff;

endmodule

`default_nettype wire

@@ design/segint_decide.sv @@
`default_nettype none

module segint_decide
   import segint_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire stage_ctl_type                 ctl_in_word,
   input  wire logic signed [2*COORD_BITS+1:0] rx_sy,
   input  wire logic signed [2*COORD_BITS+1:0] ry_sx,
   input  wire logic signed [2*COORD_BITS+1:0] wx_sy,
   input  wire logic signed [2*COORD_BITS+1:0] wy_sx,
   input  wire logic signed [2*COORD_BITS+1:0] wx_ry,
   input  wire logic signed [2*COORD_BITS+1:0] wy_rx,
   output logic                               out_valid,
   output logic                               crosses,
   output logic [1:0]                         outcome
);

   localparam int SW = 2*COORD_BITS + 3;

   stage_ctl_type        ctl_ff;
   logic signed [SW-1:0] d_ff, nt_ff, nu_ff;
   logic                 valid_ff, valid_in;
   outcome_type          outcome_ff, outcome_in;
   logic                 d_pos, nt_ok, nu_ok;

   // determinant and the two numerators
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in_word;
      end
   end

   always_ff @(posedge clock) begin
      d_ff  <= SW'(rx_sy) - SW'(ry_sx);
      nt_ff <= SW'(wx_sy) - SW'(wy_sx);
      nu_ff <= SW'(wx_ry) - SW'(wy_rx);
   end

   // range checks of both numerators against the determinant
   always_comb begin
      d_pos = !d_ff[SW-1] && (d_ff != '0);
      if (d_pos) begin
         nt_ok = !nt_ff[SW-1] && (nt_ff <= d_ff);
         nu_ok = !nu_ff[SW-1] && (nu_ff <= d_ff);
      end else begin
         nt_ok = ((nt_ff == '0) || nt_ff[SW-1]) && (nt_ff >= d_ff);
         nu_ok = ((nu_ff == '0) || nu_ff[SW-1]) && (nu_ff >= d_ff);
      end
   end

   // point before parallel before range
   always_comb begin
      valid_in = ctl_ff.valid;
      if (ctl_ff.point) begin
         outcome_in = OUT_POINT;
      end else if (d_ff == '0) begin
         outcome_in = OUT_PARALLEL;
      end else if (nt_ok && nu_ok) begin
         outcome_in = OUT_CROSS;
      end else begin
         outcome_in = OUT_MISS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      outcome_ff <= outcome_in;
   end

   assign out_valid = valid_ff;
   assign crosses   = (outcome_ff == OUT_CROSS);
   assign outcome   = outcome_ff;

endmodule

`default_nettype wire

@@ design/segment_intersection_test.sv @@
`default_nettype none

// channel    ports                                   handshake
// request    req_seg1_*, req_seg2_* (start/end x,y)  start high, busy low
// response   rsp_crosses, rsp_outcome                rsp_valid, one cycle
//
// one segment pair accepted every clock; busy never rises
// four register stages: difference, multiply, determinant subtract, range compare;
// the response is on the ports from the range compare register
// synchronous reset clears the valid bits of all stages, data is not reset
// the receiver cannot stall, so the pipeline never holds

module segment_intersection_test
   import segint_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [FIELD_BITS-1:0] req_seg1_start_x,
   input  wire logic signed [FIELD_BITS-1:0] req_seg1_start_y,
   input  wire logic signed [FIELD_BITS-1:0] req_seg1_end_x,
   input  wire logic signed [FIELD_BITS-1:0] req_seg1_end_y,
   input  wire logic signed [FIELD_BITS-1:0] req_seg2_start_x,
   input  wire logic signed [FIELD_BITS-1:0] req_seg2_start_y,
   input  wire logic signed [FIELD_BITS-1:0] req_seg2_end_x,
   input  wire logic signed [FIELD_BITS-1:0] req_seg2_end_y,
   output logic                              rsp_valid,
   output logic                              rsp_crosses,
   output logic [1:0]                        rsp_outcome
);

   localparam int PW = 2*COORD_BITS + 2;

   logic                        accept;
   logic                        diff_valid;
   logic signed [COORD_BITS:0]  rx, ry, sx, sy, wx, wy;
   stage_ctl_type               mult_ctl;
   logic signed [PW-1:0]        rx_sy, ry_sx, wx_sy, wy_sx, wx_ry, wy_rx;

   // fully pipelined, always ready
   assign busy   = 1'b0;
   assign accept = start && !busy;

   segint_diff #(
      .COORD_BITS(COORD_BITS)
   ) u_diff (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (accept),
      .seg1_start_x (req_seg1_start_x),
      .seg1_start_y (req_seg1_start_y),
      .seg1_end_x   (req_seg1_end_x),
      .seg1_end_y   (req_seg1_end_y),
      .seg2_start_x (req_seg2_start_x),
      .seg2_start_y (req_seg2_start_y),
      .seg2_end_x   (req_seg2_end_x),
      .seg2_end_y   (req_seg2_end_y),
      .out_valid    (diff_valid),
      .rx           (rx),
      .ry           (ry),
      .sx           (sx),
      .sy           (sy),
      .wx           (wx),
      .wy           (wy)
   );

   segint_mult #(
      .COORD_BITS(COORD_BITS)
   ) u_mult (
      .clock    (clock),
      .reset    (reset),
      .in_valid (diff_valid),
      .rx       (rx),
      .ry       (ry),
      .sx       (sx),
      .sy       (sy),
      .wx       (wx),
      .wy       (wy),
      .ctl_out  (mult_ctl),
      .rx_sy    (rx_sy),
      .ry_sx    (ry_sx),
      .wx_sy    (wx_sy),
      .wy_sx    (wy_sx),
      .wx_ry    (wx_ry),
      .wy_rx    (wy_rx)
   );

   segint_decide #(
      .COORD_BITS(COORD_BITS)
   ) u_decide (
      .clock       (clock),
      .reset       (reset),
      .ctl_in_word (mult_ctl),
      .rx_sy       (rx_sy),
      .ry_sx       (ry_sx),
      .wx_sy       (wx_sy),
      .wy_sx       (wy_sx),
      .wx_ry       (wx_ry),
      .wy_rx       (wy_rx),
      .out_valid   (rsp_valid),
      .crosses     (rsp_crosses),
      .outcome     (rsp_outcome)
   );

endmodule

`default_nettype wire
